// ===== src/assert_macros.svh =====
// Assertion macros for the checker module of the charge monitor.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CME_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define CME_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== src/cme_pkg.sv =====
// Package of the charge mode and energy monitor: widths, constants, codes.
// Used by every module of the block; depends on nothing.
package cme_pkg;

  // Field widths.
  localparam int TimeW    = 32;
  localparam int VoltW    = 17;
  localparam int CurrW    = 16;
  localparam int EnergyW  = 64;
  localparam int DtW      = 13;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int ItemInW  = 72;
  localparam int ItemOutW = 72;

  // Error quotient: |diff| * 10000 fits in 31 bits.
  localparam int DivQW    = 31;
  localparam int DivCntW  = $clog2(DivQW);
  localparam int ErrSumW  = DivQW + 1;

  // Energy increment: V * I * dt.
  localparam int ViW      = VoltW + CurrW;
  localparam int AddW     = ViW + DtW;
  localparam int MulCntW  = $clog2(CurrW);

  // Thresholds and limits.
  localparam logic [DtW-1:0]     DtCapMs     = DtW'(5000);
  localparam logic [ErrSumW-1:0] HystErr     = ErrSumW'(25);
  localparam logic [VoltW-1:0]   VChargeMv   = VoltW'(1000);
  localparam logic [CurrW-1:0]   IChargeMa   = CurrW'(50);
  localparam logic [VoltW-1:0]   VsetMinMv   = VoltW'(100);
  localparam logic [CurrW-1:0]   IsetMinMa   = CurrW'(50);
  localparam logic [CurrW-1:0]   IsetFloorMa = CurrW'(100);
  localparam logic [TimeW-1:0]   PauseResetDefMs = TimeW'(300000);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgVoltSet = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCurrSet = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChgEn   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPauseMs = 2'd3;

  typedef enum logic [ModeW-1:0] {
    ModeOff = 2'd0,
    ModeCv  = 2'd1,
    ModeCc  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StBusy = 2'b10
  } state_e;

  // Multiply by 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4 with shifts and adds.
  function automatic logic [DivQW-1:0] scale_err(input logic [VoltW-1:0] d);
    logic [DivQW-1:0] x;
    x = DivQW'(d);
    return (x << 13) + (x << 10) + (x << 9) + (x << 8) + (x << 4);
  endfunction

endpackage

// ===== src/cme_divider.sv =====
// Bit-serial restoring divider for the relative setpoint errors.
// One quotient bit per cycle; depends on cme_pkg.
module cme_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cme_pkg::DivQW-1:0] dividend_i,
  input  logic [cme_pkg::VoltW-1:0] divisor_i,
  output logic                      done_o,
  output logic [cme_pkg::DivQW-1:0] quotient_o
);

  logic                        busy_q, busy_d;
  logic [cme_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [cme_pkg::VoltW-1:0]   rem_q, rem_d;
  logic [cme_pkg::DivQW-1:0]   quo_q, quo_d;
  logic [cme_pkg::VoltW-1:0]   dsr_q, dsr_d;
  logic [cme_pkg::VoltW:0]     trial;
  logic                        fits;

  // The dividend shifts out of the top of quo_q while quotient bits enter below.
  assign trial = {rem_q, quo_q[cme_pkg::DivQW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = cme_pkg::DivCntW'(cme_pkg::DivQW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? cme_pkg::VoltW'(trial - {1'b0, dsr_q}) : trial[cme_pkg::VoltW-1:0];
      quo_d = {quo_q[cme_pkg::DivQW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/cme_energy_mult.sv =====
// Bit-serial shift-add multiplier forming voltage * current * elapsed time.
// Current bits first, then time bits, most significant first; depends on cme_pkg.
module cme_energy_mult (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cme_pkg::VoltW-1:0] volt_i,
  input  logic [cme_pkg::CurrW-1:0] curr_i,
  input  logic [cme_pkg::DtW-1:0]   dt_i,
  output logic                     done_o,
  output logic [cme_pkg::AddW-1:0]  product_o
);

  logic                        busy_q, busy_d;
  logic                        phase_q, phase_d;
  logic [cme_pkg::MulCntW-1:0] cnt_q, cnt_d;
  logic [cme_pkg::VoltW-1:0]   volt_q, volt_d;
  logic [cme_pkg::CurrW-1:0]   curr_sh_q, curr_sh_d;
  logic [cme_pkg::DtW-1:0]     dt_sh_q, dt_sh_d;
  logic [cme_pkg::ViW-1:0]     vi_q, vi_d;
  logic [cme_pkg::AddW-1:0]    acc_q, acc_d;

  always_comb begin
    busy_d    = busy_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    volt_d    = volt_q;
    curr_sh_d = curr_sh_q;
    dt_sh_d   = dt_sh_q;
    vi_d      = vi_q;
    acc_d     = acc_q;
    if (start_i) begin
      busy_d    = 1'b1;
      phase_d   = 1'b0;
      cnt_d     = cme_pkg::MulCntW'(cme_pkg::CurrW - 1);
      volt_d    = volt_i;
      curr_sh_d = curr_i;
      dt_sh_d   = dt_i;
      vi_d      = '0;
      acc_d     = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (!phase_q) begin
        vi_d      = (vi_q << 1) + (curr_sh_q[cme_pkg::CurrW-1] ?
                                   cme_pkg::ViW'(volt_q) : '0);
        curr_sh_d = curr_sh_q << 1;
        if (cnt_q == '0) begin
          phase_d = 1'b1;
          cnt_d   = cme_pkg::MulCntW'(cme_pkg::DtW - 1);
        end
      end else begin
        acc_d   = (acc_q << 1) + (dt_sh_q[cme_pkg::DtW-1] ?
                                  cme_pkg::AddW'(vi_q) : '0);
        dt_sh_d = dt_sh_q << 1;
        if (cnt_q == '0) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    volt_q    <= volt_d;
    curr_sh_q <= curr_sh_d;
    dt_sh_q   <= dt_sh_d;
    vi_q      <= vi_d;
    acc_q     <= acc_d;
  end

  assign done_o    = !busy_q;
  assign product_o = acc_q;

endmodule

// ===== src/charge_mode_and_energy_monitor.sv =====
// Charge mode and energy monitor: one result item per measurement item.
// Items are taken one at a time: the next item is accepted only after the result
// of the current one is registered, which waits on the 31-step bit-serial error dividers.
// The output register lets the next item enter while a result waits.
// Reset (rst_ni low, asynchronous) clears all history, the energy to zero,
// the mode to off, and the registers to zero except the pause length (300000 ms).
// Depends on cme_pkg, cme_divider and cme_energy_mult.
module charge_mode_and_energy_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [cme_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cme_pkg::CfgDataW-1:0]   cfg_data_i,
  // Measurement items.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: now_ms[31:0], voltage_mv[48:32], current_ma[64:49],
  //        charger_ready[65], zero fill [71:66]
  input  logic [cme_pkg::ItemInW-1:0]    s_axis_tdata,
  // Result items.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: regulation_mode[1:0], is_charging[2], energy_nj[66:3],
  //        zero fill [71:67]
  output logic [cme_pkg::ItemOutW-1:0]   m_axis_tdata
);

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [cme_pkg::VoltW-1:0] vset_q;
  logic [cme_pkg::CurrW-1:0] iset_q;
  logic                      chg_en_q;
  logic [cme_pkg::TimeW-1:0] pause_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vset_q     <= '0;
      iset_q     <= '0;
      chg_en_q   <= 1'b0;
      pause_ms_q <= cme_pkg::PauseResetDefMs;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cme_pkg::CfgVoltSet: vset_q     <= cfg_data_i[cme_pkg::VoltW-1:0];
        cme_pkg::CfgCurrSet: iset_q     <= cfg_data_i[cme_pkg::CurrW-1:0];
        cme_pkg::CfgChgEn:   chg_en_q   <= cfg_data_i[0];
        cme_pkg::CfgPauseMs: pause_ms_q <= cfg_data_i[cme_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input decode. The block takes an item only in the idle state; all of
  // the work for an item is launched on the accept edge.
  // ---------------------------------------------------------------------
  cme_pkg::state_e state_q, state_d;

  logic                      in_acc;
  logic [cme_pkg::TimeW-1:0] in_now;
  logic [cme_pkg::VoltW-1:0] in_volt;
  logic [cme_pkg::CurrW-1:0] in_curr;
  logic                      in_ready;
  logic                      in_chg;

  assign s_axis_tready = (state_q == cme_pkg::StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_now        = s_axis_tdata[31:0];
  assign in_volt       = s_axis_tdata[48:32];
  assign in_curr       = s_axis_tdata[64:49];
  assign in_ready      = s_axis_tdata[65];

  // A sample counts as charging only with charging enabled, the charger
  // ready and both voltage and current above their presence thresholds.
  assign in_chg = chg_en_q && in_ready && (in_volt > cme_pkg::VChargeMv) &&
                  (in_curr > cme_pkg::IChargeMa);

  // Absolute setpoint differences, scaled to hundredths of a percent
  // numerators. The current divisor never drops below 100 mA.
  logic [cme_pkg::VoltW-1:0] vdiff;
  logic [cme_pkg::CurrW-1:0] idiff;
  logic [cme_pkg::VoltW-1:0] idivisor;

  assign vdiff    = (in_volt >= vset_q) ? (in_volt - vset_q) : (vset_q - in_volt);
  assign idiff    = (in_curr >= iset_q) ? (in_curr - iset_q) : (iset_q - in_curr);
  assign idivisor = (iset_q > cme_pkg::IsetFloorMa) ? {1'b0, iset_q} :
                                                      {1'b0, cme_pkg::IsetFloorMa};

  // Elapsed time since the previous sample, wrapping, capped at 5000 ms.
  logic [cme_pkg::TimeW-1:0] last_time_q;
  logic [cme_pkg::TimeW-1:0] dt_full;
  logic [cme_pkg::DtW-1:0]   dt_capped;

  assign dt_full   = in_now - last_time_q;
  assign dt_capped = (dt_full > cme_pkg::TimeW'(cme_pkg::DtCapMs)) ?
                     cme_pkg::DtCapMs : dt_full[cme_pkg::DtW-1:0];

  // ---------------------------------------------------------------------
  // Serial arithmetic units. Both errors divide in parallel; the energy
  // increment multiplies alongside and finishes first.
  // ---------------------------------------------------------------------
  logic                      vdiv_done, idiv_done, mult_done;
  logic [cme_pkg::DivQW-1:0] verr, ierr;
  logic [cme_pkg::AddW-1:0]  energy_add;

  cme_divider u_vdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (cme_pkg::scale_err(vdiff)),
    .divisor_i  (vset_q),
    .done_o     (vdiv_done),
    .quotient_o (verr)
  );

  cme_divider u_idiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (cme_pkg::scale_err({1'b0, idiff})),
    .divisor_i  (idivisor),
    .done_o     (idiv_done),
    .quotient_o (ierr)
  );

  cme_energy_mult u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .volt_i    (in_volt),
    .curr_i    (in_curr),
    .dt_i      (dt_capped),
    .done_o    (mult_done),
    .product_o (energy_add)
  );

  // Fields of the item in flight that are needed at the end.
  logic                      chg_q;
  logic [cme_pkg::TimeW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chg_q <= in_chg;
      now_q <= in_now;
    end
  end

  // ---------------------------------------------------------------------
  // Finish: once every unit is done and the output register is free, the
  // result is written and the history state is updated in the same cycle.
  // ---------------------------------------------------------------------
  logic fin;
  logic m_valid_q, m_valid_d;

  assign fin = (state_q == cme_pkg::StBusy) && vdiv_done && idiv_done && mult_done &&
               (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cme_pkg::StIdle: if (in_acc) state_d = cme_pkg::StBusy;
      cme_pkg::StBusy: if (fin)    state_d = cme_pkg::StIdle;
      default:                     state_d = cme_pkg::StIdle;
    endcase
  end

  // Regulation mode. The mode is off, and the held mode forgotten, when the
  // sample is not charging or a setpoint is too small to judge against.
  // Otherwise the error that is clearly smaller names the regulating loop;
  // close errors keep the held mode, or pick one if none is held.
  cme_pkg::mode_e              held_q, held_d, mode_d;
  logic                        mode_off;
  logic [cme_pkg::ErrSumW-1:0] verr_w, ierr_w;

  assign verr_w   = cme_pkg::ErrSumW'(verr);
  assign ierr_w   = cme_pkg::ErrSumW'(ierr);
  assign mode_off = !chg_q || (vset_q < cme_pkg::VsetMinMv) ||
                    (iset_q < cme_pkg::IsetMinMa);

  always_comb begin
    held_d = held_q;
    if (mode_off) begin
      held_d = cme_pkg::ModeOff;
    end else if (ierr_w + cme_pkg::HystErr < verr_w) begin
      held_d = cme_pkg::ModeCc;
    end else if (verr_w + cme_pkg::HystErr < ierr_w) begin
      held_d = cme_pkg::ModeCv;
    end else if (held_q == cme_pkg::ModeOff) begin
      held_d = (verr_w <= ierr_w) ? cme_pkg::ModeCv : cme_pkg::ModeCc;
    end
    mode_d = held_d;
  end

  // Energy and pause tracking. The first sample only records its time.
  // A charging sample adds its increment with saturation and ends any pause.
  // A non-charging sample opens a pause if none is open, and clears the
  // energy once when the pause has lasted at least the configured length.
  logic                        time_valid_q, time_valid_d;
  logic [cme_pkg::TimeW-1:0]   last_time_d;
  logic [cme_pkg::TimeW-1:0]   pause_start_q, pause_start_d;
  logic                        pause_valid_q, pause_valid_d;
  logic                        pause_done_q, pause_done_d;
  logic [cme_pkg::EnergyW-1:0] energy_q, energy_d;
  logic [cme_pkg::EnergyW:0]   energy_sum;
  logic [cme_pkg::TimeW-1:0]   pause_len;

  // A pause that opens on this sample starts at its own time.
  assign energy_sum = {1'b0, energy_q} + (cme_pkg::EnergyW + 1)'(energy_add);
  assign pause_len  = now_q - (pause_valid_q ? pause_start_q : now_q);

  always_comb begin
    time_valid_d  = time_valid_q;
    last_time_d   = last_time_q;
    pause_start_d = pause_start_q;
    pause_valid_d = pause_valid_q;
    pause_done_d  = pause_done_q;
    energy_d      = energy_q;
    if (!time_valid_q) begin
      time_valid_d = 1'b1;
      last_time_d  = now_q;
    end else begin
      last_time_d = now_q;
      if (chg_q) begin
        energy_d      = energy_sum[cme_pkg::EnergyW] ? '1 :
                        energy_sum[cme_pkg::EnergyW-1:0];
        pause_valid_d = 1'b0;
        pause_done_d  = 1'b0;
      end else begin
        if (!pause_valid_q) begin
          pause_start_d = now_q;
          pause_valid_d = 1'b1;
        end
        if (!pause_done_q && (pause_len >= pause_ms_q)) begin
          energy_d     = '0;
          pause_done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= cme_pkg::StIdle;
      held_q        <= cme_pkg::ModeOff;
      time_valid_q  <= 1'b0;
      last_time_q   <= '0;
      pause_start_q <= '0;
      pause_valid_q <= 1'b0;
      pause_done_q  <= 1'b0;
      energy_q      <= '0;
    end else begin
      state_q <= state_d;
      if (fin) begin
        held_q        <= held_d;
        time_valid_q  <= time_valid_d;
        last_time_q   <= last_time_d;
        pause_start_q <= pause_start_d;
        pause_valid_q <= pause_valid_d;
        pause_done_q  <= pause_done_d;
        energy_q      <= energy_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic [cme_pkg::ItemOutW-1:0] m_data_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (fin) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      m_data_q <= {5'b0, energy_d, chg_q, mode_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== src/cme_checker.sv =====
// Port-level checker for the charge mode and energy monitor, bound to the top.
// Depends on cme_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cme_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cme_pkg::ItemOutW-1:0] m_axis_tdata
);

  // A stalled result holds.
  `CME_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // The mode code is never the unused value.
  `CME_ASSERT_NEVER(a_mode_code, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] == 2'd3, "undefined regulation mode")

  // A non-charging sample always reports mode off.
  `CME_ASSERT(a_off_when_idle, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1:0] == cme_pkg::ModeOff, "mode not off without charging")

  // One item at a time: the input closes right after an acceptance.
  `CME_ASSERT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item accepted while busy")

endmodule

bind charge_mode_and_energy_monitor cme_checker u_cme_checker (.*);
